// ----- design/assert_macros.svh -----
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/gso_pkg.sv -----
`timescale 1ns / 1ps
package gso_pkg;
  localparam int FracBitsDef = 16;
  localparam int EntryWidthDef = 20;
endpackage

// ----- design/gso_if.sv -----
`timescale 1ns / 1ps
interface gso_in_if #(parameter int EW = 20);
  logic valid;
  logic ready;
  logic signed [EW-1:0] a [9];
  modport source (output valid, a, input ready);
  modport sink (input valid, a, output ready);
endinterface

// ----- design/gso_out_if.sv -----
`timescale 1ns / 1ps
interface gso_out_if #(parameter int OW = 18);
  logic valid;
  logic ready;
  logic signed [OW-1:0] q [9];
  logic degenerate;
  modport source (output valid, q, degenerate, input ready);
  modport sink (input valid, q, degenerate, output ready);
endinterface

// ----- design/gso_norm.sv -----
`timescale 1ns / 1ps
// pipelined normalizer: squared length, bitwise square root, bitwise divide
module gso_norm import gso_pkg::*; #(
  parameter int VW = 24,
  parameter int F = FracBitsDef,
  parameter int TW = 8
) (
  input  logic clk,
  input  logic en,
  input  logic signed [VW-1:0] v [3],
  input  logic [TW-1:0] tag_in,
  output logic signed [F+1:0] q [3],
  output logic zero,
  output logic [TW-1:0] tag_out
);
  localparam int SW = 2*VW;
  localparam int RW = VW;
  localparam int NW = VW + F;
  localparam int NS = RW;
  localparam int DS = F + 2;
  localparam int NST = 1 + NS + DS;

  logic [VW-1:0] mag [3];
  logic sgn [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sgn[i] = v[i][VW-1];
      mag[i] = sgn[i] ? VW'(-v[i]) : VW'(v[i]);
    end
  end

  // stage 0: squared length, fits 2*VW bits
  logic [SW-1:0] s0;
  logic [VW-1:0] m0 [3];
  logic g0 [3];
  logic [TW-1:0] t0;
  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= SW'(mag[0]*mag[0]) + SW'(mag[1]*mag[1]) + SW'(mag[2]*mag[2]);
      m0 <= mag;
      g0 <= sgn;
      t0 <= tag_in;
    end
  end

  // square root, two radicand bits per stage
  localparam int XW = SW + 2;
  logic [XW-1:0] rs [NS+1];
  logic [XW-1:0] rm [NS+1];
  logic [RW-1:0] rr [NS+1];
  logic [VW-1:0] ms [NS+1][3];
  logic gs [NS+1][3];
  logic [TW-1:0] ts [NS+1];
  always_comb begin
    rs[0] = {s0, 2'b00}; rm[0] = '0; rr[0] = '0; ms[0] = m0; gs[0] = g0; ts[0] = t0;
  end
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [XW-1:0] rem_w;
    logic [XW-1:0] trial;
    always_comb begin
      rem_w = {rm[k][XW-3:0], rs[k][XW-1 -: 2]};
      trial = {rr[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rs[k+1] <= {rs[k][XW-3:0], 2'b00};
        if (rem_w >= trial) begin
          rm[k+1] <= rem_w - trial;
          rr[k+1] <= {rr[k][RW-2:0], 1'b1};
        end else begin
          rm[k+1] <= rem_w;
          rr[k+1] <= {rr[k][RW-2:0], 1'b0};
        end
        ms[k+1] <= ms[k];
        gs[k+1] <= gs[k];
        ts[k+1] <= ts[k];
      end
    end
  end

  // rounded divide: q = (2n + r) / 2r, one quotient bit per stage
  localparam int DW = NW + 2;
  logic [DW-1:0] dn [DS+1][3];
  logic [DW-1:0] drm [DS+1][3];
  logic [DS-1:0] dq [DS+1][3];
  logic [RW:0] dd [DS+1];
  logic gd [DS+1][3];
  logic [TW-1:0] td [DS+1];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dn[0][i] = ({{(DW-NW){1'b0}}, {ms[NS][i], {F{1'b0}}}} << 1) + DW'(rr[NS]);
      drm[0][i] = '0;
      dq[0][i] = '0;
      gd[0][i] = gs[NS][i];
    end
    dd[0] = {rr[NS], 1'b0};
    td[0] = ts[NS];
  end
  // quotient fits DS bits, so the top DW-DS bits of n are preloaded
  for (genvar k = 0; k < DS; k++) begin : g_div
    for (genvar i = 0; i < 3; i++) begin : g_l
      logic [DW:0] pr;
      always_comb begin
        if (k == 0) pr = (DW+1)'(dn[k][i] >> DS);
        else pr = {drm[k][i], dn[k][i][DS-1-k+k]};
      end
      logic [DW:0] pa;
      always_comb begin
        pa = (k == 0) ? {pr[DW-1:0], dn[k][i][DS-1]} : pr;
      end
      always_ff @(posedge clk) begin
        if (en) begin
          dn[k+1][i] <= {dn[k][i][DW-2:0], 1'b0};
          gd[k+1][i] <= gd[k][i];
          if (pa >= (DW+1)'(dd[k])) begin
            drm[k+1][i] <= DW'(pa - (DW+1)'(dd[k]));
            dq[k+1][i] <= {dq[k][i][DS-2:0], 1'b1};
          end else begin
            drm[k+1][i] <= DW'(pa);
            dq[k+1][i] <= {dq[k][i][DS-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dd[k+1] <= dd[k];
        td[k+1] <= td[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++)
      q[i] = gd[DS][i] ? -$signed({1'b0, dq[DS][i][F:0]}) : $signed({1'b0, dq[DS][i][F:0]});
    zero = (dd[DS] == '0);
    tag_out = td[DS];
  end
endmodule

// ----- design/gram_schmidt_orthonormalize_3x3_top.sv -----
`timescale 1ns / 1ps
// each normalizer takes 1 + (ENTRY_WIDTH+3) + (FRAC_BITS+2) stages, columns 1 and 2 each
// add two projection stages, and one output register closes the pipeline
// throughput: one matrix per cycle; every stage advances when the output is free
// reset clears only valid bits; payload registers are not reset
module gram_schmidt_orthonormalize_3x3_top import gso_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef,
  parameter int ENTRY_WIDTH = EntryWidthDef
) (
  input logic clk,
  input logic rst,
  gso_in_if.sink in_ch,
  gso_out_if.source out_ch
);
`include "assert_macros.svh"
  localparam int F = FRAC_BITS;
  localparam int EW = ENTRY_WIDTH;
  localparam int OW = F + 2;
  localparam int VW = EW + 3;
  localparam int LAT = 1 + VW + OW;
  localparam int MW = 9*EW;
  localparam int TOT = 3*LAT + 5;

  logic en;
  logic [TOT-1:0] vld;
  assign en = !vld[TOT-1] || out_ch.ready;
  assign in_ch.ready = en;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[TOT-2:0], in_ch.valid};
  end

  // round half away from zero, shift by F
  function automatic logic signed [63:0] rsh(input logic signed [63:0] x);
    logic [63:0] m;
    logic [63:0] r;
    begin
      m = x[63] ? 64'(-x) : 64'(x);
      r = (m + (64'(1) << (F-1))) >> F;
      return x[63] ? -$signed(r) : $signed(r);
    end
  endfunction

  logic [MW-1:0] a_in;
  always_comb
    for (int i = 0; i < 9; i++) a_in[i*EW +: EW] = in_ch.a[i];

  // column 0 normalize
  logic signed [VW-1:0] v0 [3];
  always_comb
    for (int i = 0; i < 3; i++) v0[i] = VW'($signed(in_ch.a[3*i]));
  logic signed [OW-1:0] q0 [3];
  logic z0;
  logic [MW-1:0] a1;
  gso_norm #(.VW(VW), .F(F), .TW(MW)) u_n0 (
    .clk, .en, .v(v0), .tag_in(a_in), .q(q0), .zero(z0), .tag_out(a1));

  function automatic logic signed [EW-1:0] ent(input logic [MW-1:0] m, input int i);
    return $signed(m[i*EW +: EW]);
  endfunction

  // column 1: dot product then projection removal, two stages
  logic signed [VW-1:0] d0;
  logic signed [OW-1:0] q0a [3];
  logic [MW-1:0] a2;
  logic z0a;
  always_ff @(posedge clk) begin
    if (en) begin
      d0 <= VW'(rsh(64'(q0[0]*ent(a1,1)) + 64'(q0[1]*ent(a1,4)) + 64'(q0[2]*ent(a1,7))));
      q0a <= q0; a2 <= a1; z0a <= z0;
    end
  end
  logic signed [VW-1:0] v1 [3];
  logic signed [OW-1:0] q0b [3];
  logic [MW-1:0] a3;
  logic z0b;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        v1[i] <= VW'(64'(ent(a2,3*i+1)) - rsh(64'(d0*q0a[i])));
      q0b <= q0a; a3 <= a2; z0b <= z0a;
    end
  end
  localparam int TW1 = MW + 3*OW + 1;
  logic [TW1-1:0] t1i, t1o;
  always_comb t1i = {a3, q0b[0], q0b[1], q0b[2], z0b};
  logic signed [OW-1:0] q1 [3];
  logic z1;
  gso_norm #(.VW(VW), .F(F), .TW(TW1)) u_n1 (
    .clk, .en, .v(v1), .tag_in(t1i), .q(q1), .zero(z1), .tag_out(t1o));

  logic [MW-1:0] a4;
  logic signed [OW-1:0] q0c [3];
  logic z0c;
  always_comb begin
    a4 = t1o[TW1-1 -: MW];
    q0c[0] = $signed(t1o[3*OW : 2*OW+1]);
    q0c[1] = $signed(t1o[2*OW : OW+1]);
    q0c[2] = $signed(t1o[OW : 1]);
    z0c = t1o[0];
  end

  // column 2: two dots, then removal of both projections
  logic signed [VW-1:0] e0, e1;
  logic signed [OW-1:0] p0 [3], p1 [3];
  logic [MW-1:0] a5;
  logic zz5;
  always_ff @(posedge clk) begin
    if (en) begin
      e0 <= VW'(rsh(64'(q0c[0]*ent(a4,2)) + 64'(q0c[1]*ent(a4,5)) + 64'(q0c[2]*ent(a4,8))));
      e1 <= VW'(rsh(64'(q1[0]*ent(a4,2)) + 64'(q1[1]*ent(a4,5)) + 64'(q1[2]*ent(a4,8))));
      p0 <= q0c; p1 <= q1; a5 <= a4; zz5 <= z0c || z1;
    end
  end
  logic signed [VW-1:0] v2 [3];
  logic signed [OW-1:0] p0b [3], p1b [3];
  logic zz6;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        v2[i] <= VW'(64'(ent(a5,3*i+2)) - rsh(64'(e0*p0[i])) - rsh(64'(e1*p1[i])));
      p0b <= p0; p1b <= p1; zz6 <= zz5;
    end
  end
  localparam int TW2 = 6*OW + 1;
  logic [TW2-1:0] t2i, t2o;
  always_comb t2i = {p0b[0], p0b[1], p0b[2], p1b[0], p1b[1], p1b[2], zz6};
  logic signed [OW-1:0] q2 [3];
  logic z2;
  gso_norm #(.VW(VW), .F(F), .TW(TW2)) u_n2 (
    .clk, .en, .v(v2), .tag_in(t2i), .q(q2), .zero(z2), .tag_out(t2o));

  // output register
  logic deg;
  always_comb deg = z2 || t2o[0];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        out_ch.q[3*i]   <= deg ? '0 : $signed(t2o[(6-i)*OW -: OW]);
        out_ch.q[3*i+1] <= deg ? '0 : $signed(t2o[(3-i)*OW -: OW]);
        out_ch.q[3*i+2] <= deg ? '0 : q2[i];
      end
      out_ch.degenerate <= deg;
    end
  end
  assign out_ch.valid = vld[TOT-1];

  `ASSERT_NEXT(a_stall_hold, clk, rst, out_ch.valid && !out_ch.ready, out_ch.valid)
  `ASSERT_IMPL(a_ready_free, clk, rst, !out_ch.valid |-> in_ch.ready)
endmodule

// ----- tb/tb_gram_schmidt_orthonormalize_3x3_top.sv -----
`timescale 1ns / 1ps
module tb_gram_schmidt_orthonormalize_3x3_top;
  import gso_pkg::*;

  localparam int FB = FracBitsDef;
  localparam int EW = EntryWidthDef;
  localparam int OW = FracBitsDef + 2;
  localparam int MaxCycles = 400000;

  typedef logic signed [EW-1:0] entry_t;
  typedef struct {
    entry_t a [9];
  } mat_in_t;
  typedef struct {
    logic signed [OW-1:0] q [9];
    logic degenerate;
  } mat_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int cycle_cnt = 0;
  int err_cnt = 0;
  int beats_in = 0;
  int beats_out = 0;
  int degen_cnt = 0;
  bit stim_done = 1'b0;

  mat_in_t pending_mats [$];
  mat_out_t expected_q [$];

  gso_in_if #(.EW(EW)) in_ch ();
  gso_out_if #(.OW(OW)) out_ch ();

  gram_schmidt_orthonormalize_3x3_top u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  // shift right by FB, rounding half away from zero
  function automatic longint rnd_shift(longint x);
    longint m;
    m = x < 0 ? -x : x;
    m = (m + (longint'(1) << (FB - 1))) >>> FB;
    return x < 0 ? -m : m;
  endfunction

  function automatic longint int_sqrt(longint s);
    longint res;
    longint b;
    res = 0;
    b = longint'(1) << 62;
    while (b > s) b = b >>> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // scale a vector to unit length; zero length gives 0
  function automatic bit unit_vec(input longint v [3], output longint u [3]);
    longint s;
    longint r;
    longint n;
    longint m;
    s = 0;
    for (int i = 0; i < 3; i++) s += v[i] * v[i];
    r = int_sqrt(s);
    if (r == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      n = (v[i] < 0 ? -v[i] : v[i]) << FB;
      m = (2 * n + r) / (2 * r);
      u[i] = v[i] < 0 ? -m : m;
    end
    return 1'b1;
  endfunction

  // classical gram-schmidt on the columns
  function automatic mat_out_t orthonormalize(mat_in_t mi);
    mat_out_t mo;
    longint col [3][3];
    longint qc [3][3];
    longint v [3];
    longint u [3];
    longint d0;
    longint d1;
    bit ok;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) col[c][r] = longint'(mi.a[3 * r + c]);
    v = col[0];
    ok = unit_vec(v, u);
    qc[0] = u;
    if (ok) begin
      d0 = rnd_shift(qc[0][0] * col[1][0] + qc[0][1] * col[1][1] + qc[0][2] * col[1][2]);
      for (int i = 0; i < 3; i++) v[i] = col[1][i] - rnd_shift(d0 * qc[0][i]);
      ok = unit_vec(v, u);
      qc[1] = u;
    end
    if (ok) begin
      d0 = rnd_shift(qc[0][0] * col[2][0] + qc[0][1] * col[2][1] + qc[0][2] * col[2][2]);
      d1 = rnd_shift(qc[1][0] * col[2][0] + qc[1][1] * col[2][1] + qc[1][2] * col[2][2]);
      for (int i = 0; i < 3; i++)
        v[i] = col[2][i] - rnd_shift(d0 * qc[0][i]) - rnd_shift(d1 * qc[1][i]);
      ok = unit_vec(v, u);
      qc[2] = u;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) mo.q[3 * r + c] = ok ? OW'(qc[c][r]) : '0;
    mo.degenerate = !ok;
    return mo;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp);
    $display("mismatch at beat %0d: %s got %0d expected %0d", beats_out, what, got, exp);
    err_cnt++;
  endtask

  function automatic entry_t rand_entry(int mode);
    case (mode)
      0: return entry_t'($urandom);
      1: return entry_t'($urandom_range(0, 8192)) - entry_t'(4096);
      2: return entry_t'($urandom_range(0, 2)) - entry_t'(1);
      default: return $urandom_range(0, 1) ? entry_t'(-524288) : entry_t'(524287);
    endcase
  endfunction

  task automatic push_mat(mat_in_t m);
    pending_mats.push_back(m);
  endtask

  // stimulus: directed corner matrices, then random ones
  initial begin
    mat_in_t m;
    int mode;
    int k;
    for (int i = 0; i < 9; i++) m.a[i] = '0;
    push_mat(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i % 4 == 0) ? entry_t'(65536) : '0;
    push_mat(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i % 4 == 0) ? entry_t'(-524288) : '0;
    push_mat(m);
    for (int i = 0; i < 9; i++) m.a[i] = entry_t'(524287);
    push_mat(m);
    for (int i = 0; i < 9; i++) m.a[i] = entry_t'(-524288);
    push_mat(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i % 2) ? entry_t'(524287) : entry_t'(-524288);
    push_mat(m);
    for (int i = 0; i < 9; i++) m.a[i] = entry_t'(i + 1);
    push_mat(m);
    // zero column 0, 1 and 2 in turn
    for (int c = 0; c < 3; c++) begin
      for (int i = 0; i < 9; i++) m.a[i] = entry_t'($urandom);
      for (int r = 0; r < 3; r++) m.a[3 * r + c] = '0;
      push_mat(m);
    end
    // column 1 parallel to column 0, column 2 a combination of both
    for (int i = 0; i < 3; i++) begin
      m.a[3 * i] = entry_t'($urandom_range(0, 2000)) - entry_t'(1000);
      m.a[3 * i + 1] = m.a[3 * i] * 3;
      m.a[3 * i + 2] = entry_t'($urandom);
    end
    push_mat(m);
    for (int i = 0; i < 3; i++) begin
      m.a[3 * i] = entry_t'($urandom_range(0, 2000)) - entry_t'(1000);
      m.a[3 * i + 1] = entry_t'($urandom_range(0, 2000)) - entry_t'(1000);
      m.a[3 * i + 2] = m.a[3 * i] - m.a[3 * i + 1];
    end
    push_mat(m);
    for (int i = 0; i < 9; i++) m.a[i] = (i == 0 || i == 4 || i == 8) ? entry_t'(1) : '0;
    push_mat(m);
    for (int n = 0; n < 500; n++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++)
        m.a[i] = rand_entry(mode < 5 ? 0 : mode < 7 ? 1 : mode < 9 ? 2 : 3);
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, 2);
        for (int r = 0; r < 3; r++) m.a[3 * r + k] = '0;
      end
      push_mat(m);
    end
    stim_done = 1'b1;
  end

  // reset and cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == 3) rst <= 1'b0;
    if (cycle_cnt >= MaxCycles) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Verification failed");
      $finish;
    end
  end

  // driver: present matrices at the falling edge with random gaps
  int in_gap = 0;
  bit in_busy = 1'b0;
  bit in_acc = 1'b0;
  bit out_acc = 1'b0;
  initial begin
    in_ch.valid = 1'b0;
    for (int i = 0; i < 9; i++) in_ch.a[i] = '0;
  end
  always @(negedge clk) begin
    mat_in_t m;
    if (in_busy && in_acc) begin
      in_busy = 1'b0;
      in_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
    end
    if (!in_busy && !rst && pending_mats.size() > 0) begin
      if (in_gap > 0) begin
        in_gap--;
      end else begin
        m = pending_mats.pop_front();
        for (int i = 0; i < 9; i++) in_ch.a[i] <= m.a[i];
        in_busy = 1'b1;
      end
    end
    in_ch.valid <= in_busy;
  end

  // accepted input beats feed the expected store
  always @(posedge clk) begin
    mat_in_t m;
    in_acc = !rst && in_ch.valid && in_ch.ready;
    if (in_acc) begin
      for (int i = 0; i < 9; i++) m.a[i] = in_ch.a[i];
      expected_q.push_back(orthonormalize(m));
      beats_in++;
    end
  end

  // receiver stalls
  int out_stall = 0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_acc)
        out_stall = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0;
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor: compare each output beat with the oldest expectation
  always @(posedge clk) begin
    mat_out_t e;
    out_acc = !rst && out_ch.valid && out_ch.ready;
    if (out_acc) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        $display("unexpected output beat %0d", beats_out);
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (e.degenerate) degen_cnt++;
        for (int i = 0; i < 9; i++)
          if (out_ch.q[i] !== e.q[i])
            report_mismatch($sformatf("q[%0d]", i), out_ch.q[i], e.q[i]);
        if (out_ch.degenerate !== e.degenerate)
          report_mismatch("degenerate", out_ch.degenerate, e.degenerate);
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (pending_mats.size() != 0 || in_busy || expected_q.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0d expected results never arrived", expected_q.size());
      err_cnt++;
    end
    $display("run covered %0d matrices in and %0d out, %0d degenerate",
             beats_in, beats_out, degen_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
